FILE: rtl/ddp_pkg.sv
package ddp_pkg;

    // Default chunk size in pixels and depth of the front-to-back queue.
    localparam int CHUNK_PIXELS_DEF = 480;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_VERSION_FLAG  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUSH_FLAG     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_FLAG    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RGB_TYPE_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ID    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_ID     = 3'd5;

    localparam logic [7:0] VERSION_FLAG_RST  = 8'd64;
    localparam logic [7:0] PUSH_FLAG_RST     = 8'd1;
    localparam logic [7:0] QUERY_FLAG_RST    = 8'd2;
    localparam logic [7:0] RGB_TYPE_CODE_RST = 8'd11;
    localparam logic [7:0] DISPLAY_ID_RST    = 8'd1;
    localparam logic [7:0] STATUS_ID_RST     = 8'd251;

    // Request modes.
    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_PUSH  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [3:0] SEQ_MAX     = 4'd15;
    localparam logic [3:0] HDR_LAST    = 4'd9;
    localparam logic [3:0] PIX_LAST    = 4'd2;

    // One classified request, as the back end needs it to emit its bytes.
    typedef struct packed {
        logic        has_head;
        logic        has_pix;
        logic        chunk_end;
        logic [7:0]  flags;
        logic [3:0]  seq;
        logic [7:0]  ptype;
        logic [7:0]  id;
        logic [31:0] offset;
        logic [15:0] length;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } desc_t;

    // Serializer phase: first byte of the queue head, header bytes, pixel bytes.
    typedef enum logic [1:0] {
        ST_FIRST,
        ST_HEAD,
        ST_PIX
    } ser_state_t;

endpackage

FILE: rtl/ddp_front.sv
module ddp_front #(
    parameter int CHUNK_PIXELS = ddp_pkg::CHUNK_PIXELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ddp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ddp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          accept,
    input  logic [1:0]                    mode,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic                          frame_start,
    input  logic [15:0]                   frame_pixels,
    input  logic [31:0]                   start_offset,
    output logic                          push,
    output ddp_pkg::desc_t                push_data
);
    import ddp_pkg::*;

    localparam int CP_W = (CHUNK_PIXELS > 1) ? $clog2(CHUNK_PIXELS) : 1;
    localparam logic [15:0] CHUNK_N = 16'(CHUNK_PIXELS);
    localparam logic [16:0] CHUNK_W = 17'(CHUNK_PIXELS);

    logic [7:0] version_flag_reg, push_flag_reg, query_flag_reg;
    logic [7:0] rgb_type_code_reg, display_id_reg, status_id_reg;

    logic [3:0]      seq_reg, seq_next;
    logic [15:0]     pr_reg, pr_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic [31:0]     off_reg, off_next;

    logic [15:0]     pr_e;
    logic [CP_W-1:0] cp_e;
    logic [31:0]     off_e;
    logic [15:0]     n_pix;
    logic            chunk_end;
    logic [3:0]      seq_adv;
    logic            emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_flag_reg  <= VERSION_FLAG_RST;
            push_flag_reg     <= PUSH_FLAG_RST;
            query_flag_reg    <= QUERY_FLAG_RST;
            rgb_type_code_reg <= RGB_TYPE_CODE_RST;
            display_id_reg    <= DISPLAY_ID_RST;
            status_id_reg     <= STATUS_ID_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VERSION_FLAG:  version_flag_reg  <= cfg_data;
                REG_PUSH_FLAG:     push_flag_reg     <= cfg_data;
                REG_QUERY_FLAG:    query_flag_reg    <= cfg_data;
                REG_RGB_TYPE_CODE: rgb_type_code_reg <= cfg_data;
                REG_DISPLAY_ID:    display_id_reg    <= cfg_data;
                REG_STATUS_ID:     status_id_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '0;
            pr_reg  <= '0;
            cp_reg  <= '0;
            off_reg <= '0;
        end
        else if (accept)
        begin
            seq_reg <= seq_next;
            pr_reg  <= pr_next;
            cp_reg  <= cp_next;
            off_reg <= off_next;
        end
    end

    // A frame start reloads the frame state before the pixel is looked at.
    assign pr_e  = frame_start ? frame_pixels : pr_reg;
    assign off_e = frame_start ? start_offset : off_reg;
    assign cp_e  = frame_start ? '0 : cp_reg;

    assign n_pix     = (pr_e < CHUNK_N) ? pr_e : CHUNK_N;
    assign chunk_end = ({{(17 - CP_W){1'b0}}, cp_e} + 17'd1 >= CHUNK_W) || (pr_e == 16'd1);
    assign seq_adv   = (seq_reg == SEQ_MAX) ? 4'd1 : seq_reg + 4'd1;

    always_comb
    begin
        emit      = 1'b0;
        seq_next  = seq_reg;
        pr_next   = pr_reg;
        cp_next   = cp_reg;
        off_next  = off_reg;
        push_data = '0;
        push_data.red   = red;
        push_data.green = green;
        push_data.blue  = blue;
        push_data.seq   = seq_reg;

        unique case (mode)
            MODE_PIXEL:
            begin
                pr_next  = pr_e;
                cp_next  = cp_e;
                off_next = off_e;
                if (pr_e != 16'd0)
                begin
                    emit                = 1'b1;
                    push_data.has_pix   = 1'b1;
                    push_data.chunk_end = chunk_end;
                    if (cp_e == '0)
                    begin
                        seq_next           = seq_adv;
                        push_data.has_head = 1'b1;
                        push_data.seq      = seq_adv;
                        push_data.flags    = version_flag_reg |
                                             ((n_pix == pr_e) ? push_flag_reg : 8'd0);
                        push_data.ptype    = rgb_type_code_reg;
                        push_data.id       = display_id_reg;
                        push_data.offset   = off_e;
                        push_data.length   = {n_pix[14:0], 1'b0} + n_pix;
                    end
                    pr_next  = pr_e - 16'd1;
                    cp_next  = chunk_end ? '0 : cp_e + 1'b1;
                    off_next = off_e + 32'd3;
                end
            end
            MODE_PUSH:
            begin
                emit               = 1'b1;
                push_data.has_head = 1'b1;
                push_data.flags    = version_flag_reg | push_flag_reg;
                push_data.id       = display_id_reg;
            end
            MODE_QUERY:
            begin
                emit               = 1'b1;
                push_data.has_head = 1'b1;
                push_data.flags    = version_flag_reg | query_flag_reg;
                push_data.id       = status_id_reg;
            end
            default: ;
        endcase
    end

    assign push = accept && emit;

endmodule

FILE: rtl/ddp_queue.sv
module ddp_queue #(
    parameter int DEPTH = ddp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ddp_pkg::desc_t push_data,
    output logic           full,
    input  logic           pop,
    output ddp_pkg::desc_t head,
    output logic           empty
);
    import ddp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CNT_FULL);

endmodule

FILE: rtl/ddp_back.sv
module ddp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ddp_pkg::desc_t head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_byte,
    output logic           packet_end,
    output logic           run_last
);
    import ddp_pkg::*;

    ser_state_t state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic       end_reg, end_next;
    logic       last_reg, last_next;
    logic       advance;

    function automatic logic [7:0] hdr_byte(input desc_t d, input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = d.flags;
            4'd1:    b = {4'd0, d.seq};
            4'd2:    b = d.ptype;
            4'd3:    b = d.id;
            4'd4:    b = d.offset[31:24];
            4'd5:    b = d.offset[23:16];
            4'd6:    b = d.offset[15:8];
            4'd7:    b = d.offset[7:0];
            4'd8:    b = d.length[15:8];
            default: b = d.length[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pix_byte(input desc_t d, input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = d.red;
            4'd1:    b = d.green;
            default: b = d.blue;
        endcase
        return b;
    endfunction

    // The output register takes a new beat when it is empty or being drained.
    assign advance = !empty && (!valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        last_next  = last_reg;
        pop        = 1'b0;

        if (advance)
        begin
            unique case (state_reg)
                ST_FIRST:
                begin
                    if (head.has_head)
                    begin
                        byte_next  = hdr_byte(head, 4'd0);
                        end_next   = 1'b0;
                        last_next  = 1'b0;
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        byte_next  = pix_byte(head, 4'd0);
                        end_next   = 1'b0;
                        last_next  = 1'b0;
                        state_next = ST_PIX;
                    end
                    idx_next = 4'd1;
                end
                ST_HEAD:
                begin
                    byte_next = hdr_byte(head, idx_reg);
                    if (idx_reg == HDR_LAST)
                    begin
                        // A bare header closes its packet; a chunk header goes on.
                        end_next  = !head.has_pix;
                        last_next = !head.has_pix;
                        idx_next  = 4'd0;
                        if (head.has_pix)
                        begin
                            state_next = ST_PIX;
                        end
                        else
                        begin
                            state_next = ST_FIRST;
                            pop        = 1'b1;
                        end
                    end
                    else
                    begin
                        end_next  = 1'b0;
                        last_next = 1'b0;
                        idx_next  = idx_reg + 4'd1;
                    end
                end
                ST_PIX:
                begin
                    byte_next = pix_byte(head, idx_reg);
                    if (idx_reg == PIX_LAST)
                    begin
                        end_next   = head.chunk_end;
                        last_next  = 1'b1;
                        idx_next   = 4'd0;
                        state_next = ST_FIRST;
                        pop        = 1'b1;
                    end
                    else
                    begin
                        end_next  = 1'b0;
                        last_next = 1'b0;
                        idx_next  = idx_reg + 4'd1;
                    end
                end
                default:
                begin
                    state_next = ST_FIRST;
                    idx_next   = 4'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FIRST;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (advance)
            begin
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
        last_reg <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign packet_end = end_reg;
    assign run_last   = last_reg;

endmodule

FILE: rtl/ddp_pixel_packetizer_unit.sv
// DDP pixel packetizer: turns pixel, push and query requests into the byte
// stream of DDP packets, one byte per output beat.
// Input channel: in_valid/in_stall with mode, red, green, blue, frame_start,
// frame_pixels and start_offset. A beat is taken when in_valid is high and
// in_stall is low. Output channel: out_valid/out_stall with out_byte,
// packet_end (last byte of a packet) and run_last (last byte caused by one
// input beat). Configuration: cfg_we, cfg_index, cfg_data write one of the
// six header registers per clock.
// The output serializer emits one byte per cycle while the queue holds a
// request and out_stall is low. A pixel that opens a chunk yields 13 bytes,
// any other pixel 3 bytes, and a push or query header 10 bytes; dropped
// requests yield none. The first byte of a request passes through the queue
// and then the output register. The front end accepts a beat every cycle
// while the queue has room, so in_stall rises only when the queue is full.
// Reset clears the sequence number and frame state, empties the queue and
// loads the configuration registers with their defaults. When the receiver
// stalls, the current output beat holds and the queue absorbs requests until
// it fills.
module ddp_pixel_packetizer_unit #(
    parameter int CHUNK_PIXELS = ddp_pkg::CHUNK_PIXELS_DEF,
    parameter int QUEUE_DEPTH  = ddp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ddp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     mode,
    input  logic [7:0]                     red,
    input  logic [7:0]                     green,
    input  logic [7:0]                     blue,
    input  logic                           frame_start,
    input  logic [15:0]                    frame_pixels,
    input  logic [31:0]                    start_offset,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_byte,
    output logic                           packet_end,
    output logic                           run_last
);
    import ddp_pkg::*;

    logic  accept;
    logic  q_push, q_full, q_pop, q_empty;
    desc_t q_in, q_head;

    // The front end classifies each beat and updates the frame state at once;
    // only requests that produce bytes enter the queue.
    assign accept   = in_valid && !in_stall;
    assign in_stall = q_full;

    ddp_front #(
        .CHUNK_PIXELS(CHUNK_PIXELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .mode        (mode),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_start (frame_start),
        .frame_pixels(frame_pixels),
        .start_offset(start_offset),
        .push        (q_push),
        .push_data   (q_in)
    );

    ddp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // The back end walks the queue head byte by byte and pops it as its
    // last byte is loaded into the output register.
    ddp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .packet_end(packet_end),
        .run_last  (run_last)
    );

    // Every packet ends on the last byte of the request that produced it.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_end |-> run_last)
        else $error("packet_end without run_last");

    // The bytes of one request leave without gaps.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
        else $error("gap inside the bytes of one request");

    // A queued request reaches an idle output in the next cycle.
    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty && !out_valid |=> out_valid)
        else $error("queued request did not reach the output");

    // The queue is never popped empty.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddp_pkg::*;

    // The block is built with its default chunk size, so the model of the
    // packet stream below uses the same value.
    localparam int CHUNK         = CHUNK_PIXELS_DEF;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int TAIL_CYCLES   = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int ERR_PRINT_MAX = 30;
    localparam int DIR_ROWS      = 25;

    // Mode code that the block must ignore, and the two register indexes
    // that address no register at all.
    localparam logic [1:0]           MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Flags bytes as they look with the registers at their reset values.
    localparam logic [7:0] FLAGS_OPEN  = VERSION_FLAG_RST;
    localparam logic [7:0] FLAGS_PUSH  = VERSION_FLAG_RST | PUSH_FLAG_RST;
    localparam logic [7:0] FLAGS_QUERY = VERSION_FLAG_RST | QUERY_FLAG_RST;

    // One request beat on the input channel.
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        frame_start;
        logic [15:0] frame_pixels;
        logic [31:0] start_offset;
    } req_t;

    // One byte beat on the output channel.
    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       run_end;
    } byte_rec_t;

    // One row of the directed table. Where known is set, the number of
    // bytes the request causes and its first byte are typed in by hand.
    typedef struct packed {
        req_t       req;
        logic       known;
        logic [3:0] n_bytes;
        logic [7:0] first_byte;
    } dir_row_t;

    // Receiver stall patterns.
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_kind_t;

    // The directed part: reset behavior, field extremes, every mode and the
    // corner cases of the framing (pixel with no open frame, a zero-length
    // frame, a restart in the middle of a frame, push and query between the
    // bytes of an open chunk, an ignored mode, offset wrap-around and the
    // chunk boundary at full chunk size).
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{'{MODE_PUSH,   8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 32'h0000_0000},
          1'b1, 4'd10, FLAGS_PUSH},
        '{'{MODE_QUERY,  8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF},
          1'b1, 4'd10, FLAGS_QUERY},
        '{'{MODE_PIXEL,  8'h12, 8'h34, 8'h56, 1'b0, 16'h0010, 32'h0000_0100},
          1'b1, 4'd0, 8'h00},
        '{'{MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF},
          1'b1, 4'd0, 8'h00},
        '{'{MODE_PIXEL,  8'h01, 8'h02, 8'h03, 1'b0, 16'h0000, 32'h0000_0000},
          1'b1, 4'd0, 8'h00},
        '{'{MODE_PIXEL,  8'hFF, 8'hFF, 8'hFF, 1'b1, 16'h0000, 32'hFFFF_FFFF},
          1'b1, 4'd0, 8'h00},
        '{'{MODE_PIXEL,  8'h00, 8'h00, 8'h00, 1'b1, 16'h0001, 32'h0000_0000},
          1'b1, 4'd13, FLAGS_PUSH},
        '{'{MODE_PIXEL,  8'hFF, 8'hFF, 8'hFF, 1'b1, 16'h0003, 32'hFFFF_FFFD},
          1'b1, 4'd13, FLAGS_PUSH},
        '{'{MODE_PIXEL,  8'h80, 8'h7F, 8'h01, 1'b0, 16'hFFFF, 32'hFFFF_FFFF},
          1'b1, 4'd3, 8'h80},
        '{'{MODE_QUERY,  8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 32'h0000_0000},
          1'b1, 4'd10, FLAGS_QUERY},
        '{'{MODE_PUSH,   8'hFF, 8'hFF, 8'hFF, 1'b1, 16'h0005, 32'h0000_0000},
          1'b1, 4'd10, FLAGS_PUSH},
        '{'{MODE_PIXEL,  8'hC3, 8'h3C, 8'h99, 1'b0, 16'h0000, 32'h0000_0000},
          1'b1, 4'd3, 8'hC3},
        '{'{MODE_PIXEL,  8'h11, 8'h22, 8'h33, 1'b0, 16'h0000, 32'h0000_0000},
          1'b1, 4'd0, 8'h00},
        '{'{MODE_PIXEL,  8'h5A, 8'hA5, 8'h00, 1'b1, 16'hFFFF, 32'h1234_5678},
          1'b1, 4'd13, FLAGS_OPEN},
        '{'{MODE_PIXEL,  8'h77, 8'h88, 8'h99, 1'b0, 16'h0000, 32'h0000_0000},
          1'b1, 4'd3, 8'h77},
        '{'{MODE_PIXEL,  8'h00, 8'hFF, 8'h00, 1'b1, 16'hAAAA, 32'h5555_5555},
          1'b1, 4'd13, FLAGS_OPEN},
        '{'{MODE_PIXEL,  8'hAB, 8'hCD, 8'hEF, 1'b0, 16'h1234, 32'h8765_4321},
          1'b0, 4'd0, 8'h00},
        '{'{MODE_PIXEL,  8'hFF, 8'h00, 8'hFF, 1'b1, 16'h5555, 32'hAAAA_AAAA},
          1'b1, 4'd13, FLAGS_OPEN},
        '{'{MODE_PIXEL,  8'h10, 8'h20, 8'h30, 1'b1, 16'h0002, 32'h0000_0000},
          1'b1, 4'd13, FLAGS_PUSH},
        '{'{MODE_QUERY,  8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 32'h0000_0000},
          1'b1, 4'd10, FLAGS_QUERY},
        '{'{MODE_PIXEL,  8'h40, 8'h50, 8'h60, 1'b0, 16'h0000, 32'h0000_0000},
          1'b1, 4'd3, 8'h40},
        '{'{MODE_PUSH,   8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 32'h0000_0000},
          1'b1, 4'd10, FLAGS_PUSH},
        '{'{MODE_PIXEL,  8'h01, 8'h01, 8'h01, 1'b1, 16'd480,  32'h0000_1000},
          1'b1, 4'd13, FLAGS_PUSH},
        '{'{MODE_PIXEL,  8'h02, 8'h02, 8'h02, 1'b1, 16'd481,  32'h0000_0000},
          1'b1, 4'd13, FLAGS_OPEN},
        '{'{MODE_PIXEL,  8'hAA, 8'h55, 8'h0F, 1'b1, 16'h0001, 32'hF0F0_0F0F},
          1'b1, 4'd13, FLAGS_PUSH}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            mode;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  frame_start;
    logic [15:0]           frame_pixels;
    logic [31:0]           start_offset;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            out_byte;
    logic                  packet_end;
    logic                  run_last;

    // Bytes the block still owes, oldest first.
    byte_rec_t pending_bytes [$];
    byte_rec_t head_rec;
    int        err_cnt;

    // Requests that caused at least one byte; this drives the length of
    // each random phase.
    int        productive_items;

    // Sender burst control, and the handshake between the stimulus and the
    // receiver for the long hold-off.
    int        burst_left;
    logic      no_gaps;
    logic      hold_req;
    logic      holding;

    // Our own copy of the header registers.
    logic [7:0] hdr_version;
    logic [7:0] hdr_push;
    logic [7:0] hdr_query;
    logic [7:0] hdr_rgb_type;
    logic [7:0] hdr_display;
    logic [7:0] hdr_status;

    // Our own copy of the framing state.
    logic [3:0]  seq_no;
    logic [15:0] pix_left;
    int          chunk_pos;
    logic [31:0] byte_off;

    ddp_pixel_packetizer_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .frame_start  (frame_start),
        .frame_pixels (frame_pixels),
        .start_offset (start_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .packet_end   (packet_end),
        .run_last     (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Packet stream model.
    // ------------------------------------------------------------------

    function automatic void put_byte(input logic [7:0] val, input logic last);
        byte_rec_t rec;
        rec.data    = val;
        rec.pkt_end = last;
        rec.run_end = 1'b0;
        pending_bytes.push_back(rec);
    endfunction

    // The ten header bytes. Offset and length go out big-endian, and the
    // sequence number is whatever the current one is at this point.
    function automatic void put_header(input logic [7:0] flags, input logic [7:0] ptype,
                                       input logic [7:0] id, input logic [31:0] offset,
                                       input logic [15:0] length, input logic last);
        put_byte(flags, 1'b0);
        put_byte({4'h0, seq_no}, 1'b0);
        put_byte(ptype, 1'b0);
        put_byte(id, 1'b0);
        put_byte(offset[31:24], 1'b0);
        put_byte(offset[23:16], 1'b0);
        put_byte(offset[15:8], 1'b0);
        put_byte(offset[7:0], 1'b0);
        put_byte(length[15:8], 1'b0);
        put_byte(length[7:0], last);
    endfunction

    // Appends the bytes that one accepted request causes and returns how
    // many there are.
    function automatic int packetize(input req_t r);
        int          start;
        logic [15:0] chunk_n;
        logic [15:0] chunk_len;
        logic [7:0]  flags;
        logic        chunk_end;
        start = pending_bytes.size();
        if (r.mode == MODE_PUSH)
        begin
            put_header(hdr_version | hdr_push, 8'h00, hdr_display, 32'h0, 16'h0, 1'b1);
        end
        else if (r.mode == MODE_QUERY)
        begin
            put_header(hdr_version | hdr_query, 8'h00, hdr_status, 32'h0, 16'h0, 1'b1);
        end
        else if (r.mode == MODE_PIXEL)
        begin
            if (r.frame_start)
            begin
                pix_left  = r.frame_pixels;
                byte_off  = r.start_offset;
                chunk_pos = 0;
            end
            if (pix_left == 16'd0)
            begin
                return 0;
            end
            if (chunk_pos == 0)
            begin
                // Opening a chunk: the last chunk of the frame carries push.
                chunk_n   = (pix_left < CHUNK) ? pix_left : 16'(CHUNK);
                chunk_len = chunk_n * 16'd3;
                flags     = hdr_version;
                if (chunk_n == pix_left)
                begin
                    flags = flags | hdr_push;
                end
                seq_no = (seq_no == SEQ_MAX) ? 4'd1 : seq_no + 4'd1;
                put_header(flags, hdr_rgb_type, hdr_display, byte_off, chunk_len, 1'b0);
            end
            chunk_end = (chunk_pos + 1 >= CHUNK) || (pix_left == 16'd1);
            put_byte(r.red, 1'b0);
            put_byte(r.green, 1'b0);
            put_byte(r.blue, chunk_end);
            pix_left  = pix_left - 16'd1;
            chunk_pos = chunk_end ? 0 : chunk_pos + 1;
            byte_off  = byte_off + 32'd3;
        end
        else
        begin
            return 0;
        end
        pending_bytes[pending_bytes.size() - 1].run_end = 1'b1;
        return pending_bytes.size() - start;
    endfunction

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            err_cnt++;
            if (err_cnt <= ERR_PRINT_MAX)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            end
        end
    endfunction

    // Outputs are sampled on the falling edge, away from the rising edge at
    // which the block updates them; a beat seen here with stall low is the one
    // taken at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= ERR_PRINT_MAX)
                begin
                    $error("output beat 0x%0h arrived with no byte pending", out_byte);
                end
            end
            else
            begin
                head_rec = pending_bytes.pop_front();
                check_field("out_byte", 32'(head_rec.data), 32'(out_byte));
                check_field("packet_end", 32'(head_rec.pkt_end), 32'(packet_end));
                check_field("run_last", 32'(head_rec.run_end), 32'(run_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Drives one request and holds it until the block takes it. The stall
    // is sampled on the falling edge, so acceptance at the following rising
    // edge is known without a race. The model is updated at that edge.
    // Between bursts the sender drops valid for a random gap.
    task automatic offer(input req_t r, output int n_res, output logic [7:0] lead);
        logic taken;
        in_valid     <= 1'b1;
        mode         <= r.mode;
        red          <= r.red;
        green        <= r.green;
        blue         <= r.blue;
        frame_start  <= r.frame_start;
        frame_pixels <= r.frame_pixels;
        start_offset <= r.start_offset;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        n_res = packetize(r);
        lead  = (n_res > 0) ? pending_bytes[pending_bytes.size() - n_res].data : 8'h00;
        if (n_res > 0)
        begin
            productive_items++;
        end
        if (!no_gaps)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(0, 30);
            end
        end
    endtask

    // Stops sending and waits until every pending byte has come out, then
    // waits out a tail for requests that cause no bytes but may still be in flight.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_VERSION_FLAG:  hdr_version  = val;
            REG_PUSH_FLAG:     hdr_push     = val;
            REG_QUERY_FLAG:    hdr_query    = val;
            REG_RGB_TYPE_CODE: hdr_rgb_type = val;
            REG_DISPLAY_ID:    hdr_display  = val;
            REG_STATUS_ID:     hdr_status   = val;
            default:           ;
        endcase
    endtask

    // Writes all six header registers, plus both unused indexes, which must
    // leave every register alone.
    task automatic load_regs(input logic [7:0] ver, input logic [7:0] pushf,
                             input logic [7:0] queryf, input logic [7:0] rgbt,
                             input logic [7:0] disp, input logic [7:0] stat);
        write_reg(REG_VERSION_FLAG, ver);
        write_reg(REG_PUSH_FLAG, pushf);
        write_reg(REG_QUERY_FLAG, queryf);
        write_reg(REG_RGB_TYPE_CODE, rgbt);
        write_reg(REG_DISPLAY_ID, disp);
        write_reg(REG_STATUS_ID, stat);
        write_reg(REG_SPARE_LO, 8'($urandom()));
        write_reg(REG_SPARE_HI, 8'($urandom()));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // A pixel request. Frame size and offset are random when frame_start is
    // low, since the block must ignore them there.
    function automatic req_t pixel_req(input logic fs, input logic [15:0] fp);
        req_t r;
        r.mode        = MODE_PIXEL;
        r.red         = 8'($urandom());
        r.green       = 8'($urandom());
        r.blue        = 8'($urandom());
        r.frame_start = fs;
        if (fs)
        begin
            r.frame_pixels = fp;
            if ($urandom_range(0, 4) == 0)
            begin
                r.start_offset = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
            end
            else
            begin
                r.start_offset = $urandom();
            end
        end
        else
        begin
            r.frame_pixels = 16'($urandom());
            r.start_offset = $urandom();
        end
        return r;
    endfunction

    function automatic req_t header_req();
        req_t r;
        r = pixel_req(1'($urandom_range(0, 1)), 16'($urandom()));
        r.mode = ($urandom_range(0, 1) == 0) ? MODE_PUSH : MODE_QUERY;
        return r;
    endfunction

    // Anything the fields allow, including the ignored mode and zero-length
    // frames.
    function automatic req_t noise_req();
        req_t r;
        r = pixel_req($urandom_range(0, 3) == 0, 16'($urandom()));
        r.mode = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
        begin
            r.frame_pixels = 16'h0000;
        end
        return r;
    endfunction

    // Opens a frame of npix pixels and sends the first nsend of them, with
    // the odd push or query dropped in between pixels.
    task automatic send_frame(input int npix, input int nsend);
        int         n_res;
        logic [7:0] lead;
        offer(pixel_req(1'b1, 16'(npix)), n_res, lead);
        for (int i = 1; i < nsend; i++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                offer(header_req(), n_res, lead);
            end
            offer(pixel_req(1'b0, 16'h0000), n_res, lead);
        end
    endtask

    // Mostly complete, small frames with random content; the rest are
    // frames cut short by the next frame start, longer frames and noise.
    task automatic random_phase(input int quota);
        int         goal;
        int         kind;
        int         n;
        int         n_res;
        logic [7:0] lead;
        goal = productive_items + quota;
        while (productive_items < goal)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                n = $urandom_range(1, 12);
                send_frame(n, n);
                if ($urandom_range(0, 2) == 0)
                begin
                    offer(header_req(), n_res, lead);
                end
            end
            else if (kind < 72)
            begin
                n = $urandom_range(2, 30);
                send_frame(n, $urandom_range(1, n - 1));
            end
            else if (kind < 80)
            begin
                n = $urandom_range(25, 120);
                send_frame(n, n);
            end
            else
            begin
                repeat ($urandom_range(1, 4)) offer(noise_req(), n_res, lead);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall patterns of its own, and on request one long hold-off
    // so that the request queue inside the block fills up and the block
    // stalls its input.
    // ------------------------------------------------------------------

    initial
    begin : receiver
        stall_kind_t seg_kind;
        int          seg_len;
        int          stall_pct;
        int          period;
        out_stall = 1'b0;
        holding   = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                holding = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holding  = 1'b0;
            end
            else
            begin
                seg_kind  = stall_kind_t'($urandom_range(0, 2));
                seg_len   = $urandom_range(10, 150);
                stall_pct = $urandom_range(10, 75);
                period    = $urandom_range(2, 5);
                for (int c = 0; c < seg_len; c++)
                begin
                    case (seg_kind)
                        STALL_NONE:   out_stall <= 1'b0;
                        STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < stall_pct);
                        default:      out_stall <= ((c % period) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: a run that has not ended by now has hung.
    initial
    begin : watchdog
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int         n_res;
        logic [7:0] lead;

        // Every input is known from time zero.
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_VERSION_FLAG;
        cfg_data     = 8'h00;
        in_valid     = 1'b0;
        mode         = MODE_PIXEL;
        red          = 8'h00;
        green        = 8'h00;
        blue         = 8'h00;
        frame_start  = 1'b0;
        frame_pixels = 16'h0000;
        start_offset = 32'h0000_0000;

        err_cnt          = 0;
        productive_items = 0;
        burst_left       = 0;
        no_gaps          = 1'b0;
        hold_req         = 1'b0;

        // The model starts from the reset state of the block.
        hdr_version  = VERSION_FLAG_RST;
        hdr_push     = PUSH_FLAG_RST;
        hdr_query    = QUERY_FLAG_RST;
        hdr_rgb_type = RGB_TYPE_CODE_RST;
        hdr_display  = DISPLAY_ID_RST;
        hdr_status   = STATUS_ID_RST;
        seq_no       = 4'd0;
        pix_left     = 16'd0;
        chunk_pos    = 0;
        byte_off     = 32'd0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table with the registers at their reset values. Every
        // row is checked byte by byte against the model; the typed-in count
        // and first byte also pin the model itself down on the easy rows.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            offer(DIR_TAB[i].req, n_res, lead);
            if (DIR_TAB[i].known)
            begin
                check_field("result count", 32'(DIR_TAB[i].n_bytes), 32'(n_res));
                if (n_res > 0)
                begin
                    check_field("first byte", 32'(DIR_TAB[i].first_byte), 32'(lead));
                end
            end
        end
        settle();

        // All registers cleared. The receiver first holds off for a long
        // stretch while the sender offers a frame back to back, so the
        // block backs up all the way to its input. Once the hold-off ends
        // the sender goes back to bursts. The frame spans more than one
        // full chunk so that a chunk closes on its size limit.
        load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        hold_req = 1'b1;
        while (!holding)
        begin
            @(posedge clk);
        end
        no_gaps = 1'b1;
        fork
            begin
                wait (hold_req == 1'b0);
                no_gaps = 1'b0;
            end
        join_none
        send_frame(CHUNK + $urandom_range(1, 12), CHUNK + 1);
        settle();

        // All registers set.
        load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        random_phase(10);
        settle();

        // Random registers.
        load_regs(8'($urandom()), 8'($urandom()), 8'($urandom()),
                  8'($urandom()), 8'($urandom()), 8'($urandom()));
        random_phase(10);
        settle();

        if (err_cnt == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ddp_pkg.sv
rtl/ddp_front.sv
rtl/ddp_queue.sv
rtl/ddp_back.sv
rtl/ddp_pixel_packetizer_unit.sv
bench/tb.sv
